FILE: src/lcf_pkg.sv
package lcf_pkg;

    localparam int MAX_TAPS   = 7;
    localparam int SMP_W      = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SMP_W + COEF_W;
    localparam int SUM_W      = 34;
    localparam int TAP_CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int NUM_REGS   = MAX_TAPS + 1;
    localparam int CFG_IDX_W  = $clog2(NUM_REGS);
    localparam int CFG_DATA_W = (COEF_W > TAP_CNT_W) ? COEF_W : TAP_CNT_W;

    // adder tree is padded up to a power of two, at least one level
    localparam int TREE_LVL   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TREE_N     = 1 << TREE_LVL;

    // register map
    localparam int REG_TAP_COUNT = 0;
    localparam int REG_COEF_0    = 1;

    typedef logic signed [SMP_W-1:0]    t_smp;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic        [TAP_CNT_W-1:0] t_tap_cnt;

    // beat travelling down the pipeline
    typedef struct packed {
        logic vld;
        logic fin;
    } t_beat;

    // control broadcast to every cell
    typedef struct packed {
        logic adv;
        logic shift;
        logic clr;
    } t_cell_ctl;

endpackage

FILE: src/lcf_if.sv
interface lcf_in_if;
    import lcf_pkg::*;

    logic valid;
    logic ready;
    t_smp sample;
    logic end_of_sequence;

    modport source (output valid, output sample, output end_of_sequence, input ready);
    modport sink   (input valid, input sample, input end_of_sequence, output ready);
endinterface

interface lcf_out_if;
    import lcf_pkg::*;

    logic valid;
    logic ready;
    t_sum conv_value;
    logic final_result;

    modport source (output valid, output conv_value, output final_result, input ready);
    modport sink   (input valid, input conv_value, input final_result, output ready);
endinterface

FILE: src/linear_convolution_fir_unit.sv
// Channel   Dir  Payload                            Beat taken when
// i_in      in   sample, end_of_sequence            valid && ready
// o_out     out  conv_value, final_result           valid && ready
// i_cfg_*   in   index, data (tap_count, coef_0..6) i_cfg_we
//
// One sample per cycle while the output skid entry is empty; a sample marked
// end_of_sequence holds the input off while its tap_count-1 zero tail beats go
// through the cell row. An accepted sample passes the products registered on
// the accepting edge, the registered adder tree and the output buffer head.
// Synchronous reset clears the delay line and all valids; no clearing pass.
// A two-entry output buffer absorbs back-pressure, so i_in.ready never depends
// combinationally on o_out.ready.
module linear_convolution_fir_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lcf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lcf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    lcf_in_if.sink                            i_in,
    lcf_out_if.source                         o_out
);
    import lcf_pkg::*;

    t_tap_cnt  r_tap_cnt;
    t_coef     r_coef [MAX_TAPS];
    t_tap_cnt  w_taps;

    t_tap_cnt  r_tail;
    t_tap_cnt  n_tail;
    logic      w_adv;
    logic      w_issue;
    logic      w_fin;
    t_cell_ctl w_cell_ctl;
    t_smp      w_x    [MAX_TAPS+1];
    t_prod     w_prod [MAX_TAPS];
    logic      w_dl_zero;

    t_beat     r_p_ctl;
    t_beat     w_t_ctl;
    t_sum      w_t_sum;

    logic      r_hv, n_hv, r_hf, n_hf;
    t_sum      r_hd, n_hd;
    logic      r_sv, n_sv, r_sf, n_sf;
    t_sum      r_sd, n_sd;
    logic      w_push;
    logic      w_pop;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_cnt <= t_tap_cnt'(1);
            for (int k = 0; k < MAX_TAPS; k++) begin
                r_coef[k] <= (k == 0) ? t_coef'(1) : t_coef'(0);
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_IDX_W'(REG_TAP_COUNT)) begin
                r_tap_cnt <= i_cfg_data[TAP_CNT_W-1:0];
            end
            for (int k = 0; k < MAX_TAPS; k++) begin
                if (i_cfg_idx == CFG_IDX_W'(REG_COEF_0 + k)) begin
                    r_coef[k] <= i_cfg_data[COEF_W-1:0];
                end
            end
        end
    end

    // zero means one tap, anything above the row length saturates
    always_comb begin
        if (r_tap_cnt == '0) begin
            w_taps = t_tap_cnt'(1);
        end else if (r_tap_cnt > t_tap_cnt'(MAX_TAPS)) begin
            w_taps = t_tap_cnt'(MAX_TAPS);
        end else begin
            w_taps = r_tap_cnt;
        end
    end

    // ---------------- beat issue ----------------
    assign w_adv      = !r_sv;
    assign i_in.ready = w_adv && (r_tail == '0);
    assign w_issue    = w_adv && ((r_tail != '0) || i_in.valid);
    assign w_x[0]     = (r_tail != '0) ? t_smp'(0) : i_in.sample;

    always_comb begin
        if (r_tail != '0) begin
            w_fin = (r_tail == t_tap_cnt'(1));
        end else begin
            w_fin = i_in.end_of_sequence && (w_taps == t_tap_cnt'(1));
        end
    end

    always_comb begin
        n_tail = r_tail;
        if (w_adv) begin
            if (r_tail != '0) begin
                n_tail = r_tail - 1'b1;
            end else if (i_in.valid && i_in.end_of_sequence) begin
                n_tail = w_taps - 1'b1;
            end
        end
    end

    assign w_cell_ctl.adv   = w_adv;
    assign w_cell_ctl.shift = w_issue;
    assign w_cell_ctl.clr   = w_issue && w_fin;

    // ---------------- cell row ----------------
    genvar g;
    generate
        for (g = 0; g < MAX_TAPS; g++) begin : g_cell
            lcf_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_cell_ctl),
                .i_x    (w_x[g]),
                .i_coef (r_coef[g]),
                .i_use  (t_tap_cnt'(g) < w_taps),
                .o_smp  (w_x[g+1]),
                .o_prod (w_prod[g])
            );
        end
    endgenerate

    always_comb begin
        w_dl_zero = 1'b1;
        for (int k = 1; k <= MAX_TAPS; k++) begin
            if (w_x[k] != '0) begin
                w_dl_zero = 1'b0;
            end
        end
    end

    lcf_adder_tree u_tree (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (w_adv),
        .i_ctl  (r_p_ctl),
        .i_prod (w_prod),
        .o_ctl  (w_t_ctl),
        .o_sum  (w_t_sum)
    );

    // ---------------- output buffer ----------------
    assign w_push = w_adv && w_t_ctl.vld;
    assign w_pop  = r_hv && o_out.ready;

    always_comb begin
        n_hv = r_hv;
        n_hd = r_hd;
        n_hf = r_hf;
        n_sv = r_sv;
        n_sd = r_sd;
        n_sf = r_sf;
        if (w_pop) begin
            if (r_sv) begin
                n_hd = r_sd;
                n_hf = r_sf;
                n_sv = 1'b0;
            end else begin
                n_hv = w_push;
                n_hd = w_t_sum;
                n_hf = w_t_ctl.fin;
            end
        end else if (w_push) begin
            if (!r_hv) begin
                n_hv = 1'b1;
                n_hd = w_t_sum;
                n_hf = w_t_ctl.fin;
            end else begin
                n_sv = 1'b1;
                n_sd = w_t_sum;
                n_sf = w_t_ctl.fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail  <= '0;
            r_p_ctl <= '0;
            r_hv    <= 1'b0;
            r_sv    <= 1'b0;
        end else begin
            r_tail <= n_tail;
            if (w_adv) begin
                r_p_ctl.vld <= w_issue;
                r_p_ctl.fin <= w_fin;
            end
            r_hv <= n_hv;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hd <= n_hd;
        r_hf <= n_hf;
        r_sd <= n_sd;
        r_sf <= n_sf;
    end

    assign o_out.valid        = r_hv;
    assign o_out.conv_value   = r_hd;
    assign o_out.final_result = r_hf;

`ifndef SYNTHESIS
    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_hv)
        else $error("skid entry held while head empty");

    a_line_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_fin) |=> w_dl_zero)
        else $error("delay line not cleared after final beat");

    a_tail_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.end_of_sequence && (w_taps != t_tap_cnt'(1)))
        |=> (r_tail == t_tap_cnt'($past(w_taps) - 1'b1)))
        else $error("tail count not loaded from tap count");

    a_tail_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_tail != '0) && w_adv) |=> (r_tail == t_tap_cnt'($past(r_tail) - 1'b1)))
        else $error("tail count did not step");
`endif

endmodule

FILE: src/lcf_cell.sv
module lcf_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lcf_pkg::t_cell_ctl i_ctl,
    input  lcf_pkg::t_smp      i_x,
    input  lcf_pkg::t_coef     i_coef,
    input  logic               i_use,
    output lcf_pkg::t_smp      o_smp,
    output lcf_pkg::t_prod     o_prod
);
    import lcf_pkg::*;

    t_smp  r_smp;
    t_prod r_prod;

    // delay line tap: takes the neighbour's sample on every issued beat, zero on a final beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp <= '0;
        end else if (i_ctl.shift) begin
            r_smp <= i_ctl.clr ? t_smp'(0) : i_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_prod <= i_use ? t_prod'(i_x * i_coef) : t_prod'(0);
        end
    end

    assign o_smp  = r_smp;
    assign o_prod = r_prod;

endmodule

FILE: src/lcf_adder_tree.sv
module lcf_adder_tree (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  lcf_pkg::t_beat  i_ctl,
    input  lcf_pkg::t_prod  i_prod [lcf_pkg::MAX_TAPS],
    output lcf_pkg::t_beat  o_ctl,
    output lcf_pkg::t_sum   o_sum
);
    import lcf_pkg::*;

    // heap order: node k has children 2k+1 and 2k+2, leaves from TREE_N-1 on
    t_sum  w_node [2*TREE_N-1];
    t_sum  r_node [TREE_N-1];
    t_beat r_ctl  [TREE_LVL];

    genvar g;
    generate
        for (g = 0; g < TREE_N; g++) begin : g_leaf
            if (g < MAX_TAPS) begin : g_prod
                assign w_node[TREE_N-1+g] = t_sum'(i_prod[g]);
            end else begin : g_pad
                assign w_node[TREE_N-1+g] = '0;
            end
        end
        for (g = 0; g < TREE_N-1; g++) begin : g_inner
            assign w_node[g] = r_node[g];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < TREE_N-1; k++) begin
                r_node[k] <= w_node[2*k+1] + w_node[2*k+2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TREE_LVL; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (i_adv) begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k < TREE_LVL; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    assign o_ctl = r_ctl[TREE_LVL-1];
    assign o_sum = r_node[0];

endmodule
